@@ rtl/gsbc_pkg.sv @@
`default_nettype none

package gsbc_pkg;

	// chain geometry
	localparam int MAX_SITES  = 256;
	localparam int IDX_W      = $clog2(MAX_SITES);
	localparam int LEN_W      = IDX_W + 1;
	localparam int COUNT_BITS = 32;
	localparam int OUT_CNT_W  = 32;
	localparam int OUT_IDX_W  = 8;

	// fixed point widths, probabilities are unsigned q16 with one at 2^16
	localparam int Q_W    = 17;
	localparam int FRAC_W = 16;
	localparam int M1_W   = 33;
	localparam int W_W    = 49;
	localparam int SUM_W  = W_W + 1;
	localparam int SPLIT  = SUM_W / 2;
	localparam int PP_W   = FRAC_W + SPLIT;
	localparam int CMP_W  = FRAC_W + SUM_W;

	localparam logic [Q_W-1:0] Q_ONE = Q_W'(65536);

	// configuration port
	localparam int CFG_AW = 4;
	localparam int CFG_DW = 32;

	localparam logic [1:0] REG_P_STAY   = 2'd0;
	localparam logic [1:0] REG_P_OBS_T  = 2'd1;
	localparam logic [1:0] REG_P_OBS_F  = 2'd2;

	localparam logic [Q_W-1:0] RST_P_STAY  = Q_W'(45875);
	localparam logic [Q_W-1:0] RST_P_OBS_T = Q_W'(58982);
	localparam logic [Q_W-1:0] RST_P_OBS_F = Q_W'(13107);

	// item actions
	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_LOAD   = 2'd1;
	localparam logic [1:0] ACT_UPDATE = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_LEFT,
		ST_RD_RIGHT,
		ST_RD_LAST,
		ST_ADD,
		ST_PROD,
		ST_CMP,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		RDS_LEFT,
		RDS_RIGHT,
		RDS_LAST
	} rd_sel_t;

	typedef struct packed {
		logic     capture;
		rd_sel_t  rd_sel;
		logic     mul1;
		logic     mul2;
		logic     add;
		logic     prod;
		logic     cmp;
		logic     commit;
	} cmd_t;

	typedef struct packed {
		logic upd_go;
	} stat_t;

	typedef struct packed {
		logic [Q_W-1:0] p_stay;
		logic [Q_W-1:0] p_obs_t;
		logic [Q_W-1:0] p_obs_f;
	} cfg_t;

	// one minus p, saturating at zero
	function automatic logic [Q_W-1:0] q_comp(input logic [Q_W-1:0] p);
		logic [Q_W-1:0] r;
		r = Q_ONE - p;
		if (p[Q_W-1]) begin
			r = '0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/gsbc_regs.sv @@
`default_nettype none

module gsbc_regs import gsbc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CFG_AW-1:0] paddr,
	input  wire logic [CFG_DW-1:0] pwdata,
	output logic      [CFG_DW-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	logic [Q_W-1:0] p_stay_q;
	logic [Q_W-1:0] p_obs_t_q;
	logic [Q_W-1:0] p_obs_f_q;
	logic           wr_en;
	logic [1:0]     reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[3:2];

	// register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_stay_q  <= RST_P_STAY;
			p_obs_t_q <= RST_P_OBS_T;
			p_obs_f_q <= RST_P_OBS_F;
		end else if (wr_en) begin
			case (reg_idx)
				REG_P_STAY:  p_stay_q  <= pwdata[Q_W-1:0];
				REG_P_OBS_T: p_obs_t_q <= pwdata[Q_W-1:0];
				REG_P_OBS_F: p_obs_f_q <= pwdata[Q_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_idx)
			REG_P_STAY:  prdata = CFG_DW'(p_stay_q);
			REG_P_OBS_T: prdata = CFG_DW'(p_obs_t_q);
			REG_P_OBS_F: prdata = CFG_DW'(p_obs_f_q);
			default:     prdata = '0;
		endcase
	end

	assign cfg.p_stay  = p_stay_q;
	assign cfg.p_obs_t = p_obs_t_q;
	assign cfg.p_obs_f = p_obs_f_q;

endmodule

`default_nettype wire

@@ rtl/gsbc_dp.sv @@
`default_nettype none

module gsbc_dp import gsbc_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cmd_t                 cmd,
	output stat_t                     stat,
	input  wire cfg_t                 cfg,
	input  wire logic [1:0]           action,
	input  wire logic                 evidence_bit,
	input  wire logic                 initial_state,
	input  wire logic [FRAC_W-1:0]    random_fraction,
	output logic      [OUT_IDX_W-1:0] site_index,
	output logic                      site_state,
	output logic      [OUT_CNT_W-1:0] true_count,
	output logic      [OUT_CNT_W-1:0] false_count,
	output logic                      sweep_end
);

	// chain control state
	logic [LEN_W-1:0]      len_q;
	logic [IDX_W-1:0]      next_q;
	logic [COUNT_BITS-1:0] tcnt_q;
	logic [COUNT_BITS-1:0] fcnt_q;

	// captured item
	logic [1:0]        op_q;
	logic              go_q;
	logic              ev_in_q;
	logic              init_q;
	logic [FRAC_W-1:0] rf_q;
	logic [IDX_W-1:0]  t_q;
	logic [IDX_W-1:0]  last_idx_q;
	logic              first_q;
	logic              at_last_q;

	// site stores
	logic ev_mem    [MAX_SITES];
	logic chain_mem [MAX_SITES];
	logic ev_rd_q;
	logic chain_rd_q;

	// arithmetic registers
	logic [M1_W-1:0]  m1t_q, m1f_q;
	logic [W_W-1:0]   wt_q, wf_q;
	logic [SUM_W-1:0] sum_q;
	logic             lastb_q;
	logic [PP_W-1:0]  plo_q, phi_q;
	logic             newb_q;

	logic [IDX_W-1:0] t_cur;
	logic [IDX_W-1:0] last_cur;
	logic [IDX_W-1:0] rd_addr;

	logic [Q_W-1:0] stay, flip;
	logic [Q_W-1:0] emit_t, emit_f;
	logic [Q_W-1:0] left_t, left_f;
	logic [Q_W-1:0] right_t, right_f;
	logic [2*Q_W-1:0]    p1t, p1f;
	logic [M1_W+Q_W-1:0] p2t, p2f;
	logic [PP_W-1:0]     pp_lo, pp_hi;
	logic [CMP_W-1:0]    lhs, rhs;

	logic [LEN_W-1:0]      len_d;
	logic [IDX_W-1:0]      next_d;
	logic [COUNT_BITS-1:0] tcnt_d, fcnt_d;
	logic                  chain_we, ev_we;
	logic [IDX_W-1:0]      wr_addr;
	logic                  chain_wd;
	logic [LEN_W-1:0]      t_inc;
	logic                  last_now;
	logic [IDX_W-1:0]      idx_d;
	logic                  state_d;
	logic                  end_d;

	// site to work on, wrapping a stale pointer to the first site
	assign t_cur       = ({1'b0, next_q} < len_q) ? next_q : '0;
	assign last_cur    = IDX_W'(len_q - LEN_W'(1));
	assign stat.upd_go = (action == ACT_UPDATE) && (len_q != '0);

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q       <= action;
			go_q       <= stat.upd_go;
			ev_in_q    <= evidence_bit;
			init_q     <= initial_state;
			rf_q       <= random_fraction;
			t_q        <= t_cur;
			last_idx_q <= last_cur;
			first_q    <= (t_cur == '0);
			at_last_q  <= (t_cur == last_cur);
		end
	end

	// neighbor read address
	always_comb begin
		case (cmd.rd_sel)
			RDS_LEFT:  rd_addr = t_q - IDX_W'(1);
			RDS_RIGHT: rd_addr = t_q + IDX_W'(1);
			RDS_LAST:  rd_addr = last_idx_q;
			default:   rd_addr = t_q;
		endcase
	end

	// site stores, one write and one registered read each
	always_ff @(posedge clk) begin
		if (chain_we) begin
			chain_mem[wr_addr] <= chain_wd;
		end
		chain_rd_q <= chain_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ev_we) begin
			ev_mem[wr_addr] <= ev_in_q;
		end
		ev_rd_q <= ev_mem[t_q];
	end

	// factor selection
	assign stay    = cfg.p_stay;
	assign flip    = q_comp(cfg.p_stay);
	assign emit_t  = ev_rd_q ? cfg.p_obs_t : q_comp(cfg.p_obs_t);
	assign emit_f  = ev_rd_q ? cfg.p_obs_f : q_comp(cfg.p_obs_f);
	assign left_t  = first_q ? Q_ONE : (chain_rd_q ? stay : flip);
	assign left_f  = first_q ? Q_ONE : (chain_rd_q ? flip : stay);
	assign right_t = at_last_q ? Q_ONE : (chain_rd_q ? stay : flip);
	assign right_f = at_last_q ? Q_ONE : (chain_rd_q ? flip : stay);

	assign p1t   = (2*Q_W)'(emit_t) * (2*Q_W)'(left_t);
	assign p1f   = (2*Q_W)'(emit_f) * (2*Q_W)'(left_f);
	assign p2t   = (M1_W+Q_W)'(m1t_q) * (M1_W+Q_W)'(right_t);
	assign p2f   = (M1_W+Q_W)'(m1f_q) * (M1_W+Q_W)'(right_f);
	assign pp_lo = PP_W'(rf_q) * PP_W'(sum_q[SPLIT-1:0]);
	assign pp_hi = PP_W'(rf_q) * PP_W'(sum_q[SUM_W-1:SPLIT]);
	assign lhs   = {phi_q, {SPLIT{1'b0}}} + CMP_W'(plo_q);
	assign rhs   = CMP_W'({wt_q, {FRAC_W{1'b0}}});

	// weight product chain and exact draw compare
	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			m1t_q <= p1t[M1_W-1:0];
			m1f_q <= p1f[M1_W-1:0];
		end
		if (cmd.mul2) begin
			wt_q <= p2t[W_W-1:0];
			wf_q <= p2f[W_W-1:0];
		end
		if (cmd.add) begin
			sum_q   <= {1'b0, wt_q} + {1'b0, wf_q};
			lastb_q <= chain_rd_q;
		end
		if (cmd.prod) begin
			plo_q <= pp_lo;
			phi_q <= pp_hi;
		end
		if (cmd.cmp) begin
			newb_q <= (lhs < rhs);
		end
	end

	// commit of one item
	always_comb begin
		len_d    = len_q;
		next_d   = next_q;
		tcnt_d   = tcnt_q;
		fcnt_d   = fcnt_q;
		chain_we = 1'b0;
		ev_we    = 1'b0;
		wr_addr  = t_q;
		chain_wd = newb_q;
		idx_d    = '0;
		state_d  = 1'b0;
		end_d    = 1'b0;
		t_inc    = {1'b0, t_q} + LEN_W'(1);
		last_now = at_last_q ? newb_q : lastb_q;
		if (op_q == ACT_CLEAR) begin
			len_d  = '0;
			next_d = '0;
			tcnt_d = '0;
			fcnt_d = '0;
		end else if (op_q == ACT_LOAD) begin
			if (len_q < LEN_W'(MAX_SITES)) begin
				wr_addr  = len_q[IDX_W-1:0];
				chain_wd = init_q;
				chain_we = cmd.commit;
				ev_we    = cmd.commit;
				len_d    = len_q + LEN_W'(1);
				idx_d    = len_q[IDX_W-1:0];
				state_d  = init_q;
			end
		end else if (go_q) begin
			chain_we = cmd.commit;
			if (last_now) begin
				if (tcnt_q != {COUNT_BITS{1'b1}}) begin
					tcnt_d = tcnt_q + COUNT_BITS'(1);
				end
			end else begin
				if (fcnt_q != {COUNT_BITS{1'b1}}) begin
					fcnt_d = fcnt_q + COUNT_BITS'(1);
				end
			end
			next_d  = (t_inc < len_q) ? t_inc[IDX_W-1:0] : '0;
			idx_d   = t_q;
			state_d = newb_q;
			end_d   = at_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			next_q <= '0;
			tcnt_q <= '0;
			fcnt_q <= '0;
		end else if (cmd.commit) begin
			len_q  <= len_d;
			next_q <= next_d;
			tcnt_q <= tcnt_d;
			fcnt_q <= fcnt_d;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			site_index  <= OUT_IDX_W'(idx_d);
			site_state  <= state_d;
			true_count  <= OUT_CNT_W'(tcnt_d);
			false_count <= OUT_CNT_W'(fcnt_d);
			sweep_end   <= end_d;
		end
	end

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_SITES))
		else $error("chain length beyond capacity");

	a_next_in_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(next_q == '0) || ({1'b0, next_q} < len_q))
		else $error("next site outside the chain");

	a_update_site: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && op_q == ACT_UPDATE && go_q) |-> ({1'b0, t_q} < len_q))
		else $error("update of a site that was never loaded");

endmodule

`default_nettype wire

@@ rtl/gsbc_ctrl.sv @@
`default_nettype none

module gsbc_ctrl import gsbc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  wire logic  out_stall,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;
	logic   slot_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d     = state_q;
		out_valid_d = out_valid_q && out_stall;
		cmd         = '0;
		cmd.rd_sel  = RDS_LEFT;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = stat.upd_go ? ST_RD_LEFT : ST_FIN;
				end
			end
			ST_RD_LEFT: begin
				cmd.rd_sel = RDS_LEFT;
				state_d    = ST_RD_RIGHT;
			end
			ST_RD_RIGHT: begin
				cmd.rd_sel = RDS_RIGHT;
				cmd.mul1   = 1'b1;
				state_d    = ST_RD_LAST;
			end
			ST_RD_LAST: begin
				cmd.rd_sel = RDS_LAST;
				cmd.mul2   = 1'b1;
				state_d    = ST_ADD;
			end
			ST_ADD: begin
				cmd.add = 1'b1;
				state_d = ST_PROD;
			end
			ST_PROD: begin
				cmd.prod = 1'b1;
				state_d  = ST_CMP;
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				// wait until the result register can take the transfer
				if (slot_free) begin
					cmd.commit  = 1'b1;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_valid_q && out_stall) |=> (state_q == ST_FIN))
		else $error("result overwritten before its transfer");

	a_update_path: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && stat.upd_go) |=> (state_q == ST_RD_LEFT))
		else $error("update item did not start the neighbor reads");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_FIN))
		else $error("result raised outside the commit step");

endmodule

`default_nettype wire

@@ rtl/gibbs_sampler_binary_chain.sv @@
// sequence: an update on a loaded chain runs the left, right and last-site reads,
// add, product, compare and commit steps; all other items go straight to commit
// throughput: one item at a time; a commit waits while a held result stalls;
// updates are paced by three chain store reads and the multiply and compare steps
// reset: arst_n clears the chain length, site pointer, tallies and handshake state;
// the site stores stay undefined until loaded
`default_nettype none

module gibbs_sampler_binary_chain import gsbc_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           action,
	input  wire logic                 evidence_bit,
	input  wire logic                 initial_state,
	input  wire logic [FRAC_W-1:0]    random_fraction,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic      [OUT_IDX_W-1:0] site_index,
	output logic                      site_state,
	output logic      [OUT_CNT_W-1:0] true_count,
	output logic      [OUT_CNT_W-1:0] false_count,
	output logic                      sweep_end,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [CFG_AW-1:0]    paddr,
	input  wire logic [CFG_DW-1:0]    pwdata,
	output logic      [CFG_DW-1:0]    prdata,
	output logic                      pready
);

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	// configuration registers
	gsbc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer
	gsbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// chain stores, weights and tallies
	gsbc_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg             (cfg),
		.action          (action),
		.evidence_bit    (evidence_bit),
		.initial_state   (initial_state),
		.random_fraction (random_fraction),
		.site_index      (site_index),
		.site_state      (site_state),
		.true_count      (true_count),
		.false_count     (false_count),
		.sweep_end       (sweep_end)
	);

endmodule

`default_nettype wire
